FILE: src/sfwp_pkg.sv
// shared types and constants of the stack frame write profiler
// no dependencies; imported by every module of the block
`default_nettype none

package sfwp_pkg;

   // fixed field widths of the transaction ports
   localparam int OP_W       = 2;
   localparam int SIZE_W     = 16;
   localparam int WCNT_W     = 32;
   localparam int LIDX_W     = 12;
   localparam int STATUS_W   = 2;
   localparam int SPOW_W     = 5;
   localparam int LSH_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // address space and counter format (unsigned 32.FRAC_BITS)
   localparam int ADDR_BITS = 16;
   localparam int FRAC_BITS = 16;
   localparam int CNT_W     = 32 + FRAC_BITS;
   localparam int DIV_W     = ADDR_BITS + 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_POWER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_SHIFT = 1'd1;

   // command from the sequencer to the line counter store
   typedef struct packed {
      logic                 valid;
      logic                 accumulate;
      logic [ADDR_BITS-1:0] line;
      logic [CNT_W-1:0]     share;
   } line_cmd_type;

endpackage

`default_nettype wire

FILE: src/stack_frame_write_profiler.sv
// top level of the stack frame write profiler: sequencer, frame stack, csrs
// depends on sfwp_pkg, sfwp_divider and sfwp_line_store
`default_nettype none

// Downward-growing stack allocator over a 2^size_power byte space that
// profiles writes per cache line of 2^line_shift bytes. A push places the
// frame below the previous one (or at the top of memory), reports its top
// byte address and spreads write_count, as unsigned 32.16 fixed point, evenly
// over every covered line with saturating counters. A pop drops the top frame
// and a read returns one line counter. One transaction is processed at a
// time: a committed push runs the 48-step bit-serial divider that forms
// the per-line share, then walks the covered lines through the single write
// port of the counter memory. After reset a clearing pass zeroes the counter
// memory, during which req_ready stays low. A finished result sits in the
// response register, so the next transaction can be accepted while the
// previous one waits for rsp_ready.
module stack_frame_write_profiler #(
   parameter int STACK_DEPTH = 64,
   parameter int LINE_BITS   = 12
) (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [sfwp_pkg::OP_W-1:0]          req_operation,
   input  wire  [sfwp_pkg::SIZE_W-1:0]        req_frame_size,
   input  wire  [sfwp_pkg::WCNT_W-1:0]        req_write_count,
   input  wire  [sfwp_pkg::LIDX_W-1:0]        req_line_index,
   // response channel
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [sfwp_pkg::STATUS_W-1:0]      rsp_status,
   output logic [sfwp_pkg::ADDR_BITS-1:0]     rsp_frame_top,
   output logic [sfwp_pkg::CNT_W-1:0]         rsp_line_writes,
   // configuration write port
   input  wire                                csr_write_en,
   input  wire  [sfwp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [sfwp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sfwp_pkg::*;

   localparam int SD_W      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);
   localparam int NUM_LINES = 2 ** LINE_BITS;
   localparam logic [ADDR_BITS:0]   LINE_LIMIT = (ADDR_BITS + 1)'(NUM_LINES);
   localparam logic [DEPTH_W-1:0]   DEPTH_MAX  = DEPTH_W'(STACK_DEPTH);

   // sequencer states
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_EXEC   = 7'b0000010,
      S_SETUP  = 7'b0000100,
      S_DIVIDE = 7'b0001000,
      S_SPREAD = 7'b0010000,
      S_RDWAIT = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [SPOW_W-1:0] size_power_ff, size_power_in;
   logic [LSH_W-1:0]  line_shift_ff, line_shift_in;

   // stack bookkeeping
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [ADDR_BITS-1:0] tops_mem  [STACK_DEPTH];
   logic [SIZE_W-1:0]    sizes_mem [STACK_DEPTH];
   logic [ADDR_BITS-1:0] prev_top_ff;
   logic [SIZE_W-1:0]    prev_size_ff;
   logic [SD_W-1:0]      stack_rd_idx;
   logic [SD_W-1:0]      stack_wr_idx;
   logic                 stack_we;

   // captured transaction
   logic [OP_W-1:0]      op_ff, op_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [WCNT_W-1:0]    wcnt_ff, wcnt_in;
   logic [LIDX_W-1:0]    line_ff, line_in;

   // push working registers
   logic [ADDR_BITS-1:0] top_ff, top_in;
   logic [ADDR_BITS-1:0] hi_ff, hi_in;
   logic [ADDR_BITS-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0]     share_ff, share_in;

   // result being built and the response register
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [ADDR_BITS-1:0] res_top_ff, res_top_in;
   logic [CNT_W-1:0]     res_lw_ff, res_lw_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [ADDR_BITS-1:0] rsp_top_ff;
   logic [CNT_W-1:0]     rsp_lw_ff;

   // combinational helpers
   logic                 req_fire;
   logic [SPOW_W-1:0]    mem_power;
   logic [ADDR_BITS:0]   mem_span;
   logic [ADDR_BITS-1:0] mem_top;
   logic [ADDR_BITS-1:0] new_top;
   logic                 room;
   logic [ADDR_BITS:0]   lo_full;
   logic [ADDR_BITS-1:0] lo_line;
   logic [ADDR_BITS-1:0] hi_line;
   logic [DIV_W-1:0]     line_count;
   logic                 div_start;
   logic [CNT_W-1:0]     div_quotient;
   logic                 div_done;
   line_cmd_type         line_cmd;
   logic [CNT_W-1:0]     store_rd_data;
   logic                 store_ready;

   assign req_fire = req_valid & req_ready;
   assign req_ready = (state_ff == S_IDLE) & store_ready;

   // effective memory size power, clamped to the range 1 to ADDR_BITS
   always_comb begin
      mem_power = size_power_ff;
      if (size_power_ff == '0) begin
         mem_power = SPOW_W'(1);
      end else if (size_power_ff > SPOW_W'(ADDR_BITS)) begin
         mem_power = SPOW_W'(ADDR_BITS);
      end
      mem_span = (ADDR_BITS + 1)'(1) << mem_power;
      mem_top  = ADDR_BITS'(mem_span - (ADDR_BITS + 1)'(1));
   end

   // placement of a new frame and room check
   always_comb begin
      if (depth_ff == '0) begin
         new_top = mem_top;
         room    = 1'b1;
      end else begin
         new_top = prev_top_ff - ADDR_BITS'(prev_size_ff);
         room    = (prev_top_ff >= ADDR_BITS'(prev_size_ff));
      end
      if ((ADDR_BITS + 1)'(size_ff) > ({1'b0, new_top} + (ADDR_BITS + 1)'(1))) begin
         room = 1'b0;
      end
   end

   // covered line range and line count of the committed frame
   always_comb begin
      lo_full    = {1'b0, top_ff} - (ADDR_BITS + 1)'(size_ff) + (ADDR_BITS + 1)'(1);
      lo_line    = ADDR_BITS'(lo_full) >> line_shift_ff;
      hi_line    = top_ff >> line_shift_ff;
      line_count = {1'b0, hi_line} - {1'b0, lo_line} + DIV_W'(1);
   end

   assign stack_rd_idx = (depth_ff == '0) ? '0 : SD_W'(depth_ff - DEPTH_W'(1));
   assign stack_wr_idx = SD_W'(depth_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      wcnt_in       = wcnt_ff;
      line_in       = line_ff;
      top_in        = top_ff;
      hi_in         = hi_ff;
      cur_in        = cur_ff;
      share_in      = share_ff;
      res_status_in = res_status_ff;
      res_top_in    = res_top_ff;
      res_lw_in     = res_lw_ff;
      stack_we      = 1'b0;
      div_start     = 1'b0;
      rsp_load      = 1'b0;
      line_cmd      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_operation;
               size_in       = req_frame_size;
               wcnt_in       = req_write_count;
               line_in       = req_line_index;
               res_status_in = ST_OK;
               res_top_in    = '0;
               res_lw_in     = '0;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            case (op_ff)
               OP_PUSH: begin
                  // zero-size push is silently ignored
                  if (size_ff != '0) begin
                     if (depth_ff == DEPTH_MAX) begin
                        res_status_in = ST_FULL;
                     end else if (!room) begin
                        res_status_in = ST_OOM;
                     end else begin
                        top_in     = new_top;
                        res_top_in = new_top;
                        stack_we   = 1'b1;
                        depth_in   = depth_ff + DEPTH_W'(1);
                        state_in   = S_SETUP;
                     end
                  end
               end
               OP_POP: begin
                  if (depth_ff == '0) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     depth_in = depth_ff - DEPTH_W'(1);
                  end
               end
               OP_READ: begin
                  // lines beyond storage read as zero
                  if ((ADDR_BITS + 1)'(line_ff) < LINE_LIMIT) begin
                     line_cmd.valid = 1'b1;
                     line_cmd.line  = ADDR_BITS'(line_ff);
                     state_in       = S_RDWAIT;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SETUP: begin
            div_start = 1'b1;
            hi_in     = hi_line;
            cur_in    = lo_line;
            state_in  = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_done) begin
               share_in = div_quotient;
               state_in = S_SPREAD;
            end
         end
         S_SPREAD: begin
            // lines past the counter storage still count in the divisor
            if ({1'b0, cur_ff} < LINE_LIMIT) begin
               line_cmd.valid      = 1'b1;
               line_cmd.accumulate = 1'b1;
               line_cmd.line       = cur_ff;
               line_cmd.share      = share_ff;
            end
            if (cur_ff == hi_ff) begin
               state_in = S_FINISH;
            end else begin
               cur_in = cur_ff + ADDR_BITS'(1);
            end
         end
         S_RDWAIT: begin
            res_lw_in = store_rd_data;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   // configuration writes
   always_comb begin
      size_power_in = size_power_ff;
      line_shift_in = line_shift_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SIZE_POWER: size_power_in = csr_wdata;
            CSR_LINE_SHIFT: line_shift_in = csr_wdata[LSH_W-1:0];
            default: begin
               size_power_in = size_power_ff;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         depth_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         size_power_ff <= SPOW_W'(16);
         line_shift_ff <= LSH_W'(6);
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         rsp_valid_ff  <= rsp_valid_in;
         size_power_ff <= size_power_in;
         line_shift_ff <= line_shift_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      wcnt_ff       <= wcnt_in;
      line_ff       <= line_in;
      top_ff        <= top_in;
      hi_ff         <= hi_in;
      cur_ff        <= cur_in;
      share_ff      <= share_in;
      res_status_ff <= res_status_in;
      res_top_ff    <= res_top_in;
      res_lw_ff     <= res_lw_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_top_ff    <= res_top_ff;
         rsp_lw_ff     <= res_lw_ff;
      end
   end

   // frame stack memory, top of stack read back every cycle
   always_ff @(posedge clock) begin
      if (stack_we) begin
         tops_mem[stack_wr_idx]  <= new_top;
         sizes_mem[stack_wr_idx] <= size_ff;
      end
      prev_top_ff  <= tops_mem[stack_rd_idx];
      prev_size_ff <= sizes_mem[stack_rd_idx];
   end

   // per-line share: (write_count << FRAC_BITS) / covered lines
   sfwp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({wcnt_ff, {FRAC_BITS{1'b0}}}),
      .divisor  (line_count),
      .quotient (div_quotient),
      .done     (div_done)
   );

   sfwp_line_store #(
      .LINE_BITS (LINE_BITS)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (line_cmd),
      .rd_data (store_rd_data),
      .ready   (store_ready)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_frame_top   = rsp_top_ff;
   assign rsp_line_writes = rsp_lw_ff;

   // stack depth never exceeds its capacity
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_MAX)
      else $error("stack depth beyond capacity");

   // depth moves by at most one frame per transaction
   a_depth_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && depth_ff != $past(depth_ff)) |->
         (depth_ff == $past(depth_ff) + DEPTH_W'(1) ||
          depth_ff == $past(depth_ff) - DEPTH_W'(1)))
      else $error("stack depth jumped");

   // the clearing pass only runs while no transaction is in flight
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      !store_ready |-> state_ff == S_IDLE)
      else $error("counter clear overlaps a transaction");

   // the spread walk never passes the top covered line
   a_spread_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SPREAD |-> cur_ff <= hi_ff)
      else $error("line walk past frame top");

   // a pending response blocks the finished result
   a_finish_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && !rsp_ready) |=> state_ff == S_FINISH)
      else $error("result overwrote a pending response");

endmodule

`default_nettype wire

FILE: src/sfwp_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on sfwp_pkg for the counter and divisor widths
`default_nettype none

module sfwp_divider (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire  [sfwp_pkg::CNT_W-1:0]  dividend,
   input  wire  [sfwp_pkg::DIV_W-1:0]  divisor,
   output logic [sfwp_pkg::CNT_W-1:0]  quotient,
   output logic                        done
);
   import sfwp_pkg::*;

   localparam int REM_W = DIV_W + 1;
   localparam int CNT_BITS = $clog2(CNT_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    quo_ff, quo_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [REM_W-1:0]    trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      trial    = {rem_ff[REM_W-2:0], quo_ff[CNT_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(CNT_W);
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[CNT_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[CNT_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

FILE: src/sfwp_line_store.sv
// per-line write counter memory with clearing pass and saturating accumulate
// depends on sfwp_pkg for the command struct and counter width
`default_nettype none

module sfwp_line_store #(
   parameter int LINE_BITS = 12
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire sfwp_pkg::line_cmd_type  cmd,
   output logic [sfwp_pkg::CNT_W-1:0]   rd_data,
   output logic                         ready
);
   import sfwp_pkg::*;

   localparam int NUM_LINES = 2 ** LINE_BITS;

   logic [CNT_W-1:0]     counters_mem [NUM_LINES];
   logic                 clearing_ff, clearing_in;
   logic [LINE_BITS-1:0] clr_ptr_ff, clr_ptr_in;
   logic [CNT_W-1:0]     rd_data_ff;
   logic                 acc_pend_ff, acc_pend_in;
   logic [LINE_BITS-1:0] acc_addr_ff;
   logic [CNT_W-1:0]     acc_share_ff;
   logic [CNT_W:0]       sum;
   logic [CNT_W-1:0]     sat_sum;
   logic [LINE_BITS-1:0] cmd_addr;

   assign cmd_addr = cmd.line[LINE_BITS-1:0];

   always_comb begin
      clearing_in = clearing_ff;
      clr_ptr_in  = clr_ptr_ff;
      if (clearing_ff) begin
         clr_ptr_in = clr_ptr_ff + LINE_BITS'(1);
         if (clr_ptr_ff == LINE_BITS'(NUM_LINES - 1)) begin
            clearing_in = 1'b0;
         end
      end
      acc_pend_in = cmd.valid & cmd.accumulate;
      // saturate at all ones
      sum     = {1'b0, rd_data_ff} + {1'b0, acc_share_ff};
      sat_sum = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ptr_ff  <= '0;
         acc_pend_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ptr_ff  <= clr_ptr_in;
         acc_pend_ff <= acc_pend_in;
      end
   end

   // read first, write back the saturated sum in the next cycle
   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         rd_data_ff   <= counters_mem[cmd_addr];
         acc_addr_ff  <= cmd_addr;
         acc_share_ff <= cmd.share;
      end
      if (clearing_ff) begin
         counters_mem[clr_ptr_ff] <= '0;
      end else if (acc_pend_ff) begin
         counters_mem[acc_addr_ff] <= sat_sum;
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = ~clearing_ff;

endmodule

`default_nettype wire

FILE: sim/stack_frame_write_profiler_test.sv
// self-checking testbench of the stack frame write profiler
// needs sfwp_pkg and the stack_frame_write_profiler rtl with its divider and line store, nothing else
`timescale 1ns / 1ps

module stack_frame_write_profiler_test;
   import sfwp_pkg::*;

   localparam int STACK_DEPTH = 64;
   localparam int LINE_BITS   = 12;
   localparam int NUM_LINES   = 1 << LINE_BITS;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 110;
   localparam int HOLD_CYCLES = 400;
   localparam int REPLY_SLOTS = 16;

   // operation code that the block treats as a no-op
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [CNT_W-1:0] CNT_MAX  = '1;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ADDR_BITS-1:0] frame_top;
      logic [CNT_W-1:0]     line_writes;
   } frame_reply_type;

   // directed rows: predicted reply, typed-in reply, or a register write
   typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [OP_W-1:0]       op;
      logic [SIZE_W-1:0]     size;
      logic [WCNT_W-1:0]     wcnt;
      logic [LIDX_W-1:0]     line;
      logic [STATUS_W-1:0]   status;
      logic [ADDR_BITS-1:0]  top;
      logic [CNT_W-1:0]      lw;
      logic [CSR_IDX_W-1:0]  csr_sel;
      logic [CSR_DATA_W-1:0] csr_val;
   } stim_row_type;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_operation   = '0;
   logic [SIZE_W-1:0]     req_frame_size  = '0;
   logic [WCNT_W-1:0]     req_write_count = '0;
   logic [LIDX_W-1:0]     req_line_index  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ADDR_BITS-1:0]  rsp_frame_top;
   logic [CNT_W-1:0]      rsp_line_writes;
   logic                  csr_write_en    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   stack_frame_write_profiler #(
      .STACK_DEPTH (STACK_DEPTH),
      .LINE_BITS   (LINE_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_frame_size  (req_frame_size),
      .req_write_count (req_write_count),
      .req_line_index  (req_line_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_frame_top   (rsp_frame_top),
      .rsp_line_writes (rsp_line_writes),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // --------------------------------------------------------------------
   // shadow copy of the allocator: registers, frame stack, line counters
   // --------------------------------------------------------------------
   logic [SPOW_W-1:0]    size_power = 5'd16;
   logic [LSH_W-1:0]     line_shift = 4'd6;
   logic [ADDR_BITS-1:0] stack_tops  [STACK_DEPTH];
   logic [DIV_W-1:0]     stack_sizes [STACK_DEPTH];
   int unsigned          stack_depth = 0;
   logic [CNT_W-1:0]     line_count  [NUM_LINES];

   // replies still owed by the block, kept in a ring, oldest first
   frame_reply_type awaited_replies [REPLY_SLOTS];
   int unsigned     replies_sent = 0;
   int unsigned     replies_seen = 0;

   int unsigned error_count   = 0;
   int unsigned gap_pct       = 0;   // sender idle chance per transaction
   int unsigned stall_pct     = 0;   // receiver stall chance per cycle
   int unsigned hold_requests = 0;   // bumped by the sender to ask for a long hold
   int unsigned holds_served  = 0;
   int unsigned hold_left     = 0;

   initial begin
      foreach (line_count[k]) line_count[k] = '0;
   end

   // top byte a new frame would get; 0 back when the stack below has no room
   function automatic bit frame_room(output int unsigned top);
      int unsigned power;
      int unsigned prev_top;
      int unsigned prev_size;
      top = 0;
      if (stack_depth == 0) begin
         // out-of-range powers clamp to 1 and ADDR_BITS
         power = size_power;
         if (power < 1) power = 1;
         if (power > ADDR_BITS) power = ADDR_BITS;
         top = (1 << power) - 1;
         return 1'b1;
      end
      prev_top  = stack_tops[stack_depth-1];
      prev_size = stack_sizes[stack_depth-1];
      // previous frame already ends at byte 0: nothing is left below it
      if (prev_top < prev_size) return 1'b0;
      top = prev_top - prev_size;
      return 1'b1;
   endfunction

   // apply one transaction to the shadow state and return its reply
   function automatic frame_reply_type predict_reply(input logic [OP_W-1:0] op,
                                                     input logic [SIZE_W-1:0] size,
                                                     input logic [WCNT_W-1:0] wcnt,
                                                     input logic [LIDX_W-1:0] line);
      frame_reply_type    reply;
      int unsigned        top;
      bit                 room;
      longint unsigned    hi_line;
      longint unsigned    lo_line;
      longint unsigned    share;
      longint unsigned    sum;
      longint unsigned    idx;
      reply = '0;
      case (op)
         OP_PUSH: begin
            // zero-size push is dropped silently
            if (size != 0) begin
               if (stack_depth >= STACK_DEPTH) begin
                  reply.status = ST_FULL;
               end else begin
                  room = frame_room(top);
                  if (!room || size > top + 1) begin
                     reply.status = ST_OOM;
                  end else begin
                     stack_tops[stack_depth]  = top[ADDR_BITS-1:0];
                     stack_sizes[stack_depth] = DIV_W'(size);
                     stack_depth++;
                     hi_line = top >> line_shift;
                     lo_line = (top - size + 1) >> line_shift;
                     share   = wcnt;
                     share   = (share << FRAC_BITS) / (hi_line - lo_line + 1);
                     // lines past the counter store count in the divisor only
                     for (idx = lo_line; idx <= hi_line && idx < NUM_LINES; idx++) begin
                        sum = line_count[idx] + share;
                        if (sum > CNT_MAX) sum = CNT_MAX;
                        line_count[idx] = sum[CNT_W-1:0];
                     end
                     reply.frame_top = top[ADDR_BITS-1:0];
                  end
               end
            end
         end
         OP_POP: begin
            if (stack_depth == 0) reply.status = ST_EMPTY;
            else stack_depth--;
         end
         OP_READ: reply.line_writes = line_count[line];
         default: ;
      endcase
      return reply;
   endfunction

   // --------------------------------------------------------------------
   // sender side
   // --------------------------------------------------------------------

   // offer one transaction and hold it until accepted; valid is left high so
   // the caller either offers the next one right away or lowers it
   task automatic send_txn(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
                           input logic [WCNT_W-1:0] wcnt, input logic [LIDX_W-1:0] line,
                           input bit typed, input frame_reply_type typed_reply);
      frame_reply_type predicted;
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_frame_size  <= size;
      req_write_count <= wcnt;
      req_line_index  <= line;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_reply(op, size, wcnt, line);
      awaited_replies[replies_sent % REPLY_SLOTS] = typed ? typed_reply : predicted;
      replies_sent++;
   endtask

   // random idle stretch between transactions, sometimes long enough to
   // cover a whole push
   task automatic sender_gap();
      int unsigned cycles;
      if ($urandom_range(0, 99) < gap_pct) begin
         cycles = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // stop offering and wait until every reply is back
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (replies_seen != replies_sent) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // register write, only called with the block idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] sel, input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_wdata    <= val;
      if (sel == CSR_SIZE_POWER) size_power = val;
      else line_shift = val[LSH_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // directed rows; starts from reset registers (2^16 bytes, 64-byte lines)
   stim_row_type directed_rows [32] = '{
      // empty block: zero counters, empty pop, no-op code with busy fields
      '{ROW_CHECKED, OP_READ,   0,     0,            0,    ST_OK,    0,     0,       0, 0},
      '{ROW_CHECKED, OP_READ,   0,     0,            4095, ST_OK,    0,     0,       0, 0},
      '{ROW_CHECKED, OP_POP,    0,     0,            0,    ST_EMPTY, 0,     0,       0, 0},
      '{ROW_CHECKED, OP_UNUSED, 65535, 32'hFFFFFFFF, 4095, ST_OK,    0,     0,       0, 0},
      // zero-size push is ignored
      '{ROW_CHECKED, OP_PUSH,   0,     1234,         0,    ST_OK,    0,     0,       0, 0},
      // one byte at the top of memory, then a frame ending exactly at byte 0
      '{ROW_CHECKED, OP_PUSH,   1,     32'hFFFFFFFF, 0,    ST_OK,    65535, 0,       0, 0},
      '{ROW_CHECKED, OP_PUSH,   65535, 32'hFFFFFFFF, 0,    ST_OK,    65534, 0,       0, 0},
      // nothing left below byte 0
      '{ROW_CHECKED, OP_PUSH,   1,     1,            0,    ST_OOM,   0,     0,       0, 0},
      // top line got both shares: counter saturates
      '{ROW_CHECKED, OP_READ,   0,     0,            1023, ST_OK,    0,     CNT_MAX, 0, 0},
      '{ROW_ITEM,    OP_READ,   0,     0,            0,    ST_OK,    0,     0,       0, 0},
      '{ROW_CHECKED, OP_POP,    0,     0,            0,    ST_OK,    0,     0,       0, 0},
      '{ROW_CHECKED, OP_POP,    0,     0,            0,    ST_OK,    0,     0,       0, 0},
      '{ROW_CHECKED, OP_POP,    0,     0,            0,    ST_EMPTY, 0,     0,       0, 0},
      // frame too large for the room below the previous one
      '{ROW_CHECKED, OP_PUSH,   200,   1000,         0,    ST_OK,    65535, 0,       0, 0},
      '{ROW_CHECKED, OP_PUSH,   65535, 3,            0,    ST_OOM,   0,     0,       0, 0},
      '{ROW_ITEM,    OP_READ,   0,     0,            1023, ST_OK,    0,     0,       0, 0},
      '{ROW_CHECKED, OP_POP,    0,     0,            0,    ST_OK,    0,     0,       0, 0},
      // size power below range acts as 1: two-byte memory
      '{ROW_CSR,     OP_PUSH,   0,     0,            0,    ST_OK,    0,     0,       CSR_SIZE_POWER, 0},
      '{ROW_CHECKED, OP_PUSH,   2,     5,            0,    ST_OK,    1,     0,       0, 0},
      '{ROW_CHECKED, OP_PUSH,   1,     9,            0,    ST_OOM,   0,     0,       0, 0},
      '{ROW_CHECKED, OP_POP,    0,     0,            0,    ST_OK,    0,     0,       0, 0},
      '{ROW_CHECKED, OP_PUSH,   3,     9,            0,    ST_OOM,   0,     0,       0, 0},
      // size power above range acts as ADDR_BITS; byte lines past the store
      '{ROW_CSR,     OP_PUSH,   0,     0,            0,    ST_OK,    0,     0,       CSR_SIZE_POWER, 31},
      '{ROW_CSR,     OP_PUSH,   0,     0,            0,    ST_OK,    0,     0,       CSR_LINE_SHIFT, 0},
      '{ROW_CHECKED, OP_PUSH,   5,     7,            0,    ST_OK,    65535, 0,       0, 0},
      '{ROW_ITEM,    OP_READ,   0,     0,            4095, ST_OK,    0,     0,       0, 0},
      '{ROW_CHECKED, OP_POP,    0,     0,            0,    ST_OK,    0,     0,       0, 0},
      // widest lines; counters kept across register changes
      '{ROW_CSR,     OP_PUSH,   0,     0,            0,    ST_OK,    0,     0,       CSR_LINE_SHIFT, 15},
      '{ROW_CHECKED, OP_PUSH,   1,     32'hFFFFFFFF, 0,    ST_OK,    65535, 0,       0, 0},
      '{ROW_ITEM,    OP_READ,   0,     0,            1,    ST_OK,    0,     0,       0, 0},
      '{ROW_CHECKED, OP_POP,    0,     0,            0,    ST_OK,    0,     0,       0, 0},
      '{ROW_ITEM,    OP_READ,   0,     0,            0,    ST_OK,    0,     0,       0, 0}
   };

   // register settings per random phase; phase 8 draws its own
   int unsigned spow_plan [PHASES] = '{16, 16, 1, 16, 16, 4, 31, 0, 0, 10, 16, 16};
   int unsigned lsh_plan  [PHASES] = '{6, 6, 0, 0, 2, 2, 10, 3, 0, 4, 15, 6};

   initial begin : stimulus
      stim_row_type          row;
      frame_reply_type       typed_reply;
      logic [OP_W-1:0]       op;
      logic [SIZE_W-1:0]     size;
      logic [WCNT_W-1:0]     wcnt;
      logic [LIDX_W-1:0]     line;
      int unsigned           spow;
      int unsigned           lsh;
      int unsigned           push_pct;
      int unsigned           pop_pct;
      int unsigned           size_cap;
      int unsigned           room_top;
      int unsigned           pick;
      int unsigned           idle_mode;

      // synchronous reset first; the block then clears its counter
      // memory with req_ready low, which send_txn simply waits out
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.kind == ROW_CSR) begin
            drain_replies();
            write_csr(row.csr_sel, row.csr_val);
         end else begin
            typed_reply = '{status: row.status, frame_top: row.top, line_writes: row.lw};
            send_txn(row.op, row.size, row.wcnt, row.line, row.kind == ROW_CHECKED,
                     typed_reply);
         end
      end

      // random phases: registers change only with the block drained
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_replies();
         spow = (ph == 8) ? $urandom_range(0, 31) : spow_plan[ph];
         lsh  = (ph == 8) ? $urandom_range(0, 15) : lsh_plan[ph];
         write_csr(CSR_SIZE_POWER, spow[CSR_DATA_W-1:0]);
         write_csr(CSR_LINE_SHIFT, lsh[CSR_DATA_W-1:0]);

         // idle mode: none, sender idle, receiver stall, both lightly
         idle_mode = ph % 4;
         gap_pct   = (idle_mode == 1) ? 58 : (idle_mode == 3) ? 15 : 0;
         stall_pct = (idle_mode == 2) ? 58 : (idle_mode == 3) ? 15 : 0;

         // push-heavy phases drive the stack into the full state
         push_pct = (ph == 4 || ph == 11) ? 85 : 45;
         pop_pct  = (ph == 4 || ph == 11) ? 8 : 30;

         // long receiver hold while the sender keeps offering back to back
         if (ph == 8) hold_requests++;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender pause until the block has answered everything
            if (ph == 9 && n == PHASE_ITEMS / 2) drain_replies();

            pick = $urandom_range(0, 99);
            if (pick < push_pct) op = OP_PUSH;
            else if (pick < push_pct + pop_pct) op = OP_POP;
            else if (pick < 97) op = OP_READ;
            else op = OP_UNUSED;

            // frames mostly span a few lines so pushes stay short
            size_cap = 4 << line_shift;
            if (size_cap > 65535) size_cap = 65535;
            size = SIZE_W'($urandom_range(1, size_cap));
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
               size = '0;
            end else if (pick == 1 && line_shift >= 6) begin
               size = SIZE_W'($urandom_range(0, 65535));
            end else if (pick < 5 && frame_room(room_top) && room_top < 65535 &&
                         ((room_top + 1) >> line_shift) <= 64) begin
               // exact fit: frame ends on byte 0
               size = SIZE_W'(room_top + 1);
            end

            case ($urandom_range(0, 9))
               0:       wcnt = '0;
               1:       wcnt = '1;
               default: wcnt = $urandom;
            endcase

            // reads aim at the line under the current top frame half the time
            if (stack_depth != 0 && $urandom_range(0, 1) == 1)
               line = LIDX_W'(stack_tops[stack_depth-1] >> line_shift);
            else
               line = LIDX_W'($urandom_range(0, NUM_LINES - 1));

            send_txn(op, size, wcnt, line, 1'b0, '0);
            sender_gap();
         end
      end
      req_valid <= 1'b0;

      // wait for the last replies, then a little longer for strays
      while (replies_seen != replies_sent) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // --------------------------------------------------------------------
   // receiver side: compare each response transaction, then pick the
   // next ready; a long hold is counted down here when the sender asks
   // --------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      frame_reply_type want;
      if (rsp_valid && rsp_ready) begin
         if (replies_seen == replies_sent) begin
            error_count++;
            $display("%0t: response transaction with none expected: status %0d top %0d writes %0h",
                     $time, rsp_status, rsp_frame_top, rsp_line_writes);
         end else begin
            want = awaited_replies[replies_seen % REPLY_SLOTS];
            replies_seen++;
            if (rsp_status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
            end
            if (rsp_frame_top !== want.frame_top) begin
               error_count++;
               $display("%0t: frame_top expected %0d, got %0d",
                        $time, want.frame_top, rsp_frame_top);
            end
            if (rsp_line_writes !== want.line_writes) begin
               error_count++;
               $display("%0t: line_writes expected %0h, got %0h",
                        $time, want.line_writes, rsp_line_writes);
            end
         end
      end

      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // watchdog: 40 ms, several times the slowest legal run
   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
